>>> rtl/rcss_pkg.sv
// rcss_pkg: shared types and constants of the rc stick setpoint shaper
// sequencer step codes, register indexes, reset values and fixed-point constants
// no dependencies
package rcss_pkg;

   // channel widths
   localparam int REQ_W     = 112;
   localparam int RSP_W     = 64;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 26;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // sequencer steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_ASQ   = 4'd0;
   localparam logic [STEP_W-1:0] ST_AE    = 4'd1;
   localparam logic [STEP_W-1:0] ST_OFS   = 4'd2;
   localparam logic [STEP_W-1:0] ST_INNER = 4'd3;
   localparam logic [STEP_W-1:0] ST_NUM   = 4'd4;
   localparam logic [STEP_W-1:0] ST_YRCP  = 4'd5;
   localparam logic [STEP_W-1:0] ST_YCHK  = 4'd6;
   localparam logic [STEP_W-1:0] ST_YFIX  = 4'd7;
   localparam logic [STEP_W-1:0] ST_TRCP  = 4'd8;
   localparam logic [STEP_W-1:0] ST_TCHK  = 4'd9;
   localparam logic [STEP_W-1:0] ST_TFIX  = 4'd10;
   localparam logic [STEP_W-1:0] ST_SRCP  = 4'd11;
   localparam logic [STEP_W-1:0] ST_SCHK  = 4'd12;
   localparam logic [STEP_W-1:0] ST_SFIX  = 4'd13;
   localparam logic [STEP_W-1:0] ST_DONE  = 4'd14;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THR_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THR_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEADZONE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EXPO     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_STEP = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_INT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_RATE = 3'd6;

   // register reset values
   localparam logic [15:0] RST_THR_LOW  = 16'd1000;
   localparam logic [15:0] RST_THR_HIGH = 16'd2000;
   localparam logic [8:0]  RST_DEADZONE = 9'd20;
   localparam logic [8:0]  RST_EXPO     = 9'd128;
   localparam logic [11:0] RST_YAW_STEP = 12'd1280;
   localparam logic [9:0]  RST_YAW_INT  = 10'd50;
   localparam logic [9:0]  RST_MAX_RATE = 10'd135;

   // pulse limits
   localparam logic [11:0] PULSE_MIN = 12'd1000;
   localparam logic [11:0] PULSE_MAX = 12'd2000;
   localparam logic [11:0] PULSE_MID = 12'd1500;

   localparam logic [8:0]  EXPO_ONE  = 9'd256;
   localparam logic [17:0] HALF_SQ   = 18'd250000;
   localparam logic signed [17:0] YAW_LIMIT = 18'sd46080;
   localparam logic [16:0] DT_CAP    = 17'd100000;
   localparam logic [10:0] TILT_RCP  = 11'd1311;
   localparam logic signed [7:0] TILT_DEG = 8'sd60;

   // divisors and truncated reciprocals (2^34, 2^35, 2^29 scaling)
   localparam logic [32:0] DIV_YAW  = 33'd1953125;
   localparam logic [32:0] DIV_THR  = 33'd1000;
   localparam logic [32:0] DIV_SLEW = 33'd15625;
   localparam logic [25:0] RCP_YAW  = 26'd8796;
   localparam logic [25:0] RCP_THR  = 26'd34359738;
   localparam logic [25:0] RCP_SLEW = 26'd34359;

   typedef struct packed {
      logic              busy;
      logic [STEP_W-1:0] step;
      logic              fin;
   } seq_ctrl_type;

endpackage

>>> rtl/rcss_mul.sv
// rcss_mul: shared unsigned multiplier with registered product
// depends on rcss_pkg for operand widths
module rcss_mul (
   input  logic                          clock,
   input  logic [rcss_pkg::MUL_A_W-1:0]  a,
   input  logic [rcss_pkg::MUL_B_W-1:0]  b,
   output logic [rcss_pkg::MUL_P_W-1:0]  prod
);

   logic [rcss_pkg::MUL_P_W-1:0] prod_ff;
   logic [rcss_pkg::MUL_P_W-1:0] prod_in;

   assign prod_in = rcss_pkg::MUL_P_W'(a) * rcss_pkg::MUL_P_W'(b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/rcss_seq.sv
// rcss_seq: step sequencer driving the shared multiplier schedule
// depends on rcss_pkg for step codes and the control struct
module rcss_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  hold,
   output rcss_pkg::seq_ctrl_type ctrl
);

   logic                        busy_ff, busy_in;
   logic [rcss_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        last;

   assign last = (step_ff == rcss_pkg::ST_DONE);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = rcss_pkg::ST_ASQ;
      end else if (busy_ff) begin
         if (last) begin
            // final step waits for the output register to free up
            if (!hold) busy_in = 1'b0;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= rcss_pkg::ST_ASQ;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   assign ctrl.busy = busy_ff;
   assign ctrl.step = step_ff;
   assign ctrl.fin  = busy_ff && last && !hold;

endmodule

>>> rtl/rc_stick_setpoint_shaper.sv
// rc_stick_setpoint_shaper: radio frame to throttle and yaw/pitch/roll setpoints
// depends on rcss_pkg, rcss_mul (shared multiplier) and rcss_seq (step sequencer)
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | req_tdata: four pulses, now_ms, now_us
//   rsp     | out       | rsp_tvalid/tready  | rsp_tdata: throttle, yaw, pitch, roll
//           |           |                    | rsp_tuser: yaw_updated
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// a frame runs step by step through the one shared multiplier; a new word is taken
// only after the sequence has finished, and a held result can delay that finish
// req_tready is low while the sequence runs; a finished result sits in the output
// register, and the final step stalls only while that register is still held
// reset loads register defaults and clears the angles and last-update timestamps; no clearing pass
module rc_stick_setpoint_shaper (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // throttle_pulse[11:0], yaw_pulse[23:12], pitch_pulse[35:24], roll_pulse[47:36],
   // now_ms[79:48], now_us[111:80]
   input  logic [rcss_pkg::REQ_W-1:0]       req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // throttle_out[15:0], yaw_setpoint[32:16], pitch_setpoint[47:33],
   // roll_setpoint[62:48], zero[63]
   output logic [rcss_pkg::RSP_W-1:0]       rsp_tdata,
   // yaw_updated[0]
   output logic                             rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rcss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcss_pkg::CSR_DAT_W-1:0]   csr_data
);

   function automatic logic [11:0] sat_pulse(input logic [11:0] v);
      if (v < rcss_pkg::PULSE_MIN) return rcss_pkg::PULSE_MIN;
      else if (v > rcss_pkg::PULSE_MAX) return rcss_pkg::PULSE_MAX;
      else return v;
   endfunction

   // 60 - floor(3d/25) whole degrees, as Q8
   function automatic logic signed [15:0] tilt_tgt(input logic [9:0] d);
      logic [11:0]      y3;
      logic [22:0]      prd;
      logic [6:0]       q;
      logic signed [7:0] deg;
      y3  = 12'({d, 1'b0}) + 12'(d);
      prd = 23'(y3) * 23'(rcss_pkg::TILT_RCP);
      q   = prd[21:15];
      deg = rcss_pkg::TILT_DEG - $signed({1'b0, q});
      return {deg, 8'b0};
   endfunction

   function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
                                                input logic signed [15:0] tgt,
                                                input logic [14:0] lim);
      logic signed [16:0] err;
      logic signed [16:0] lim_s;
      err   = {tgt[15], tgt} - {cur[15], cur};
      lim_s = {2'b00, lim};
      if (err > lim_s) err = lim_s;
      else if (err < -lim_s) err = -lim_s;
      return cur + err[15:0];
   endfunction

   rcss_pkg::seq_ctrl_type ctrl;

   logic req_take, rsp_hold;

   // configuration
   logic [15:0] thr_lo_ff, thr_lo_in, thr_hi_ff, thr_hi_in;
   logic [8:0]  dz_ff, dz_in, expo_ff, expo_in;
   logic [11:0] ystep_ff, ystep_in;
   logic [9:0]  yint_ff, yint_in, rate_ff, rate_in;

   // persistent state
   logic signed [16:0] yaw_ang_ff, yaw_ang_in;
   logic signed [15:0] pit_ang_ff, pit_ang_in, rol_ang_ff, rol_ang_in;
   logic [31:0]        last_yaw_ff, last_yaw_in, last_slew_ff, last_slew_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // latched frame
   logic [9:0]  thr_d_ff, thr_d_in, pit_d_ff, pit_d_in, rol_d_ff, rol_d_in;
   logic [8:0]  yaw_a_ff, yaw_a_in;
   logic        yaw_pos_ff, yaw_pos_in;
   logic [31:0] now_ms_ff, now_ms_in, now_us_ff, now_us_in;

   // working registers
   logic [25:0] w1_ff, w1_in;
   logic [32:0] w2_ff, w2_in;
   logic [15:0] quo_ff, quo_in;
   logic [11:0] qy_ff, qy_in;
   logic [15:0] qt_ff, qt_in;
   logic [14:0] qs_ff, qs_in;
   logic [16:0] dt_ff, dt_in;
   logic signed [15:0] tgt_p_ff, tgt_p_in, tgt_r_ff, tgt_r_in;
   logic [rcss_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_user_ff, rsp_user_in;

   // accept side
   logic [11:0] thr_p, yaw_p, pit_p, rol_p;

   // shared multiplier
   logic [rcss_pkg::MUL_A_W-1:0] mul_a;
   logic [rcss_pkg::MUL_B_W-1:0] mul_b;
   logic [rcss_pkg::MUL_P_W-1:0] prod;

   logic [8:0]  e_sat, e_inv;
   logic [15:0] thr_span;
   logic [32:0] rem, div_sel;
   logic        fix_inc;
   logic [31:0] dt_raw;

   // finalize
   logic [15:0]        thr_new;
   logic               dz_hit, yaw_upd;
   logic signed [12:0] yaw_inc;
   logic signed [17:0] yaw_sum, yaw_clip;
   logic signed [15:0] pit_new, rol_new;
   logic signed [16:0] yaw_out;

   rcss_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_take),
      .hold  (rsp_hold),
      .ctrl  (ctrl)
   );

   rcss_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   assign req_tready = !ctrl.busy;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_hold   = rsp_valid_ff && !rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign thr_p = sat_pulse(req_tdata[11:0]);
   assign yaw_p = sat_pulse(req_tdata[23:12]);
   assign pit_p = sat_pulse(req_tdata[35:24]);
   assign rol_p = sat_pulse(req_tdata[47:36]);

   assign e_sat    = (expo_ff > rcss_pkg::EXPO_ONE) ? rcss_pkg::EXPO_ONE : expo_ff;
   assign e_inv    = rcss_pkg::EXPO_ONE - e_sat;
   assign thr_span = (thr_hi_ff >= thr_lo_ff) ? thr_hi_ff - thr_lo_ff : thr_lo_ff - thr_hi_ff;

   // quotient correction: estimate is exact or one short
   always_comb begin
      case (ctrl.step)
         rcss_pkg::ST_YFIX: div_sel = rcss_pkg::DIV_YAW;
         rcss_pkg::ST_TFIX: div_sel = rcss_pkg::DIV_THR;
         default:           div_sel = rcss_pkg::DIV_SLEW;
      endcase
   end
   assign rem     = w2_ff - prod[32:0];
   assign fix_inc = (rem >= div_sel);

   assign dt_raw = (last_slew_ff == 32'd0) ? 32'd0 : now_us_ff - last_slew_ff;

   // operand select per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.step)
         rcss_pkg::ST_ASQ: begin
            mul_a = 33'(yaw_a_ff);
            mul_b = 26'(yaw_a_ff);
         end
         rcss_pkg::ST_AE: begin
            mul_a = 33'(prod[17:0]);
            mul_b = 26'(e_sat);
         end
         rcss_pkg::ST_OFS: begin
            mul_a = 33'(rcss_pkg::HALF_SQ);
            mul_b = 26'(e_inv);
         end
         rcss_pkg::ST_INNER: begin
            mul_a = 33'(ystep_ff);
            mul_b = 26'(yaw_a_ff);
         end
         rcss_pkg::ST_NUM: begin
            mul_a = 33'(prod[20:0]);
            mul_b = w1_ff;
         end
         rcss_pkg::ST_YRCP: begin
            mul_a = prod[46:14];
            mul_b = rcss_pkg::RCP_YAW;
         end
         rcss_pkg::ST_YCHK: begin
            mul_a = 33'(prod[45:34]);
            mul_b = 26'(rcss_pkg::DIV_YAW);
         end
         rcss_pkg::ST_YFIX: begin
            mul_a = 33'(thr_d_ff);
            mul_b = 26'(thr_span);
         end
         rcss_pkg::ST_TRCP: begin
            mul_a = 33'(prod[25:0]);
            mul_b = rcss_pkg::RCP_THR;
         end
         rcss_pkg::ST_TCHK: begin
            mul_a = 33'(prod[50:35]);
            mul_b = 26'(rcss_pkg::DIV_THR);
         end
         rcss_pkg::ST_TFIX: begin
            mul_a = 33'(dt_ff);
            mul_b = 26'(rate_ff);
         end
         rcss_pkg::ST_SRCP: begin
            mul_a = {4'b0, prod[26:0], 2'b00};
            mul_b = rcss_pkg::RCP_SLEW;
         end
         rcss_pkg::ST_SCHK: begin
            mul_a = 33'(prod[43:29]);
            mul_b = 26'(rcss_pkg::DIV_SLEW);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // result assembly
   always_comb begin
      thr_new = (thr_hi_ff < thr_lo_ff) ? thr_lo_ff - qt_ff : thr_lo_ff + qt_ff;
      dz_hit  = (yaw_a_ff >= dz_ff) && (yaw_a_ff != 9'd0);
      if (!dz_hit) yaw_inc = '0;
      else if (yaw_pos_ff) yaw_inc = -$signed({1'b0, qy_ff});
      else yaw_inc = $signed({1'b0, qy_ff});
      yaw_sum = {yaw_ang_ff[16], yaw_ang_ff} + {{5{yaw_inc[12]}}, yaw_inc};
      if (yaw_sum > rcss_pkg::YAW_LIMIT) yaw_clip = rcss_pkg::YAW_LIMIT;
      else if (yaw_sum < -rcss_pkg::YAW_LIMIT) yaw_clip = -rcss_pkg::YAW_LIMIT;
      else yaw_clip = yaw_sum;
      yaw_upd = (now_ms_ff - last_yaw_ff) > 32'(yint_ff);
      yaw_out = yaw_upd ? yaw_clip[16:0] : yaw_ang_ff;
      pit_new = slew(pit_ang_ff, tgt_p_ff, qs_ff);
      rol_new = slew(rol_ang_ff, tgt_r_ff, qs_ff);
   end

   always_comb begin
      thr_lo_in    = thr_lo_ff;
      thr_hi_in    = thr_hi_ff;
      dz_in        = dz_ff;
      expo_in      = expo_ff;
      ystep_in     = ystep_ff;
      yint_in      = yint_ff;
      rate_in      = rate_ff;
      yaw_ang_in   = yaw_ang_ff;
      pit_ang_in   = pit_ang_ff;
      rol_ang_in   = rol_ang_ff;
      last_yaw_in  = last_yaw_ff;
      last_slew_in = last_slew_ff;
      rsp_valid_in = rsp_valid_ff;
      thr_d_in     = thr_d_ff;
      pit_d_in     = pit_d_ff;
      rol_d_in     = rol_d_ff;
      yaw_a_in     = yaw_a_ff;
      yaw_pos_in   = yaw_pos_ff;
      now_ms_in    = now_ms_ff;
      now_us_in    = now_us_ff;
      w1_in        = w1_ff;
      w2_in        = w2_ff;
      quo_in       = quo_ff;
      qy_in        = qy_ff;
      qt_in        = qt_ff;
      qs_in        = qs_ff;
      dt_in        = dt_ff;
      tgt_p_in     = tgt_p_ff;
      tgt_r_in     = tgt_r_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            rcss_pkg::REG_THR_LOW:  thr_lo_in = csr_data;
            rcss_pkg::REG_THR_HIGH: thr_hi_in = csr_data;
            rcss_pkg::REG_DEADZONE: dz_in     = csr_data[8:0];
            rcss_pkg::REG_EXPO:     expo_in   = csr_data[8:0];
            rcss_pkg::REG_YAW_STEP: ystep_in  = csr_data[11:0];
            rcss_pkg::REG_YAW_INT:  yint_in   = csr_data[9:0];
            rcss_pkg::REG_MAX_RATE: rate_in   = csr_data[9:0];
            default: ;
         endcase
      end

      if (req_take) begin
         thr_d_in   = 10'(thr_p - rcss_pkg::PULSE_MIN);
         pit_d_in   = 10'(pit_p - rcss_pkg::PULSE_MIN);
         rol_d_in   = 10'(rol_p - rcss_pkg::PULSE_MIN);
         yaw_pos_in = (yaw_p > rcss_pkg::PULSE_MID);
         yaw_a_in   = (yaw_p > rcss_pkg::PULSE_MID) ? 9'(yaw_p - rcss_pkg::PULSE_MID)
                                                    : 9'(rcss_pkg::PULSE_MID - yaw_p);
         now_ms_in  = req_tdata[79:48];
         now_us_in  = req_tdata[111:80];
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      if (ctrl.busy) begin
         case (ctrl.step)
            rcss_pkg::ST_ASQ: begin
               dt_in    = (dt_raw > 32'(rcss_pkg::DT_CAP)) ? rcss_pkg::DT_CAP : dt_raw[16:0];
               tgt_p_in = tilt_tgt(pit_d_ff);
               tgt_r_in = tilt_tgt(rol_d_ff);
            end
            rcss_pkg::ST_OFS:   w1_in  = prod[25:0];
            rcss_pkg::ST_INNER: w1_in  = w1_ff + prod[25:0];
            rcss_pkg::ST_YRCP:  w2_in  = prod[46:14];
            rcss_pkg::ST_YCHK:  quo_in = 16'(prod[45:34]);
            rcss_pkg::ST_YFIX:  qy_in  = quo_ff[11:0] + 12'(fix_inc);
            rcss_pkg::ST_TRCP:  w2_in  = 33'(prod[25:0]);
            rcss_pkg::ST_TCHK:  quo_in = prod[50:35];
            rcss_pkg::ST_TFIX:  qt_in  = quo_ff + 16'(fix_inc);
            rcss_pkg::ST_SRCP:  w2_in  = {4'b0, prod[26:0], 2'b00};
            rcss_pkg::ST_SCHK:  quo_in = 16'(prod[44:29]);
            rcss_pkg::ST_SFIX:  qs_in  = quo_ff[14:0] + 15'(fix_inc);
            rcss_pkg::ST_DONE: begin
               if (ctrl.fin) begin
                  yaw_ang_in   = yaw_out;
                  if (yaw_upd) last_yaw_in = now_ms_ff;
                  last_slew_in = now_us_ff;
                  pit_ang_in   = pit_new;
                  rol_ang_in   = rol_new;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {1'b0, rol_new[14:0], pit_new[14:0], yaw_out, thr_new};
                  rsp_user_in  = yaw_upd;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_lo_ff    <= rcss_pkg::RST_THR_LOW;
         thr_hi_ff    <= rcss_pkg::RST_THR_HIGH;
         dz_ff        <= rcss_pkg::RST_DEADZONE;
         expo_ff      <= rcss_pkg::RST_EXPO;
         ystep_ff     <= rcss_pkg::RST_YAW_STEP;
         yint_ff      <= rcss_pkg::RST_YAW_INT;
         rate_ff      <= rcss_pkg::RST_MAX_RATE;
         yaw_ang_ff   <= '0;
         pit_ang_ff   <= '0;
         rol_ang_ff   <= '0;
         last_yaw_ff  <= '0;
         last_slew_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_lo_ff    <= thr_lo_in;
         thr_hi_ff    <= thr_hi_in;
         dz_ff        <= dz_in;
         expo_ff      <= expo_in;
         ystep_ff     <= ystep_in;
         yint_ff      <= yint_in;
         rate_ff      <= rate_in;
         yaw_ang_ff   <= yaw_ang_in;
         pit_ang_ff   <= pit_ang_in;
         rol_ang_ff   <= rol_ang_in;
         last_yaw_ff  <= last_yaw_in;
         last_slew_ff <= last_slew_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_d_ff    <= thr_d_in;
      pit_d_ff    <= pit_d_in;
      rol_d_ff    <= rol_d_in;
      yaw_a_ff    <= yaw_a_in;
      yaw_pos_ff  <= yaw_pos_in;
      now_ms_ff   <= now_ms_in;
      now_us_ff   <= now_us_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      quo_ff      <= quo_in;
      qy_ff       <= qy_in;
      qt_ff       <= qt_in;
      qs_ff       <= qs_in;
      dt_ff       <= dt_in;
      tgt_p_ff    <= tgt_p_in;
      tgt_r_ff    <= tgt_r_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

>>> rtl/rcss_chk.sv
// rcss_chk: port-level checks of the rc stick setpoint shaper
// depends on rcss_pkg widths; bound to rc_stick_setpoint_shaper below
module rcss_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rcss_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                           rsp_tuser
);

   // a taken word starts the sequence, so no second word right after
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a frame is still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a new result only appears as the sequence finishes
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a frame in work");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[32:16]) <= 17'sd46080 && $signed(rsp_tdata[32:16]) >= -17'sd46080
         && $signed(rsp_tdata[47:33]) <= 15'sd15360 && $signed(rsp_tdata[47:33]) >= -15'sd15360
         && $signed(rsp_tdata[62:48]) <= 15'sd15360 && $signed(rsp_tdata[62:48]) >= -15'sd15360)
      else $error("setpoint out of range");

endmodule

bind rc_stick_setpoint_shaper rcss_chk u_rcss_chk (.*);

>>> tb/sv/tb.sv
// tb: self-checking bench for rc_stick_setpoint_shaper
// streams radio frames and register writes, predicts every setpoint word in-bench
// depends on rcss_pkg and the rc_stick_setpoint_shaper rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 40;
   localparam logic [rcss_pkg::CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   // signed mapping constants for the predictor
   localparam longint PW_LO     = 1000;
   localparam longint PW_HI     = 2000;
   localparam longint PW_MID    = 1500;
   localparam longint HALF_US   = 500;
   localparam longint YAW_CLAMP = 46080;
   localparam longint US_PER_S  = 1000000;
   localparam int     DT_CAP_US = 100000;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [15:0] throttle;
      logic [16:0] yaw;
      logic [14:0] pitch;
      logic [14:0] roll;
      logic        yaw_updated;
   } setpoint_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [rcss_pkg::REQ_W-1:0]       req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b1;
   logic [rcss_pkg::RSP_W-1:0]       rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [rcss_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [rcss_pkg::CSR_DAT_W-1:0]   csr_data = '0;

   rc_stick_setpoint_shaper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted register file and stick state
   logic [15:0] cfg_thr_low, cfg_thr_high;
   logic [8:0]  cfg_deadzone, cfg_expo;
   logic [11:0] cfg_yaw_step;
   logic [9:0]  cfg_yaw_int, cfg_max_rate;
   longint      yaw_sp_q8, pitch_sp_q8, roll_sp_q8;
   logic [31:0] last_yaw_ms, last_slew_us;

   logic [rcss_pkg::REQ_W-1:0] frames_pending [$];
   setpoint_type     setpoints_due [$];
   bit               frame_taken = 1'b0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   bit               holdoff_request = 1'b0;
   int               holdoff_left = 0;
   int               quiet_cycles = 0;
   int               errors = 0;
   int               words_checked = 0;
   int               yaw_updates = 0;
   int               csr_writes = 0;
   logic [31:0]      run_ms = 32'd2000;
   logic [31:0]      run_us = 32'd1300000;

   function automatic longint clamp_pulse(logic [11:0] v);
      if (v < PW_LO) return PW_LO;
      if (v > PW_HI) return PW_HI;
      return longint'(v);
   endfunction

   // whole degrees, +60 at 1000 us down to -60 at 2000 us
   function automatic longint tilt_of(longint p);
      return (60 + ((p - PW_LO) * (-120)) / (PW_HI - PW_LO)) * 256;
   endfunction

   function automatic longint move_toward(longint cur, longint target, longint step);
      longint diff;
      diff = target - cur;
      if (diff > step) diff = step;
      if (diff < -step) diff = -step;
      return cur + diff;
   endfunction

   function automatic void apply_reg(logic [rcss_pkg::CSR_IDX_W-1:0] index,
                                     logic [rcss_pkg::CSR_DAT_W-1:0] value);
      case (index)
         rcss_pkg::REG_THR_LOW:  cfg_thr_low  = value;
         rcss_pkg::REG_THR_HIGH: cfg_thr_high = value;
         rcss_pkg::REG_DEADZONE: cfg_deadzone = value[8:0];
         rcss_pkg::REG_EXPO:     cfg_expo     = value[8:0];
         rcss_pkg::REG_YAW_STEP: cfg_yaw_step = value[11:0];
         rcss_pkg::REG_YAW_INT:  cfg_yaw_int  = value[9:0];
         rcss_pkg::REG_MAX_RATE: cfg_max_rate = value[9:0];
         default: ;
      endcase
   endfunction

   function automatic setpoint_type shape_frame(logic [rcss_pkg::REQ_W-1:0] word);
      longint       tp, yp, pp, rp, lo, hi, thr, c, a, e, num, mag, yaw_inc, y, step;
      logic [31:0]  now_ms, now_us, ms_gap, dt;
      setpoint_type sp;
      tp = clamp_pulse(word[11:0]);
      yp = clamp_pulse(word[23:12]);
      pp = clamp_pulse(word[35:24]);
      rp = clamp_pulse(word[47:36]);
      now_ms = word[79:48];
      now_us = word[111:80];
      lo = longint'(cfg_thr_low);
      hi = longint'(cfg_thr_high);
      thr = lo + ((tp - PW_LO) * (hi - lo)) / (PW_HI - PW_LO);

      c = yp - PW_MID;
      a = (c < 0) ? -c : c;
      yaw_inc = 0;
      if (a >= longint'(cfg_deadzone) && a != 0) begin
         e = (cfg_expo > 9'd256) ? 256 : longint'(cfg_expo);
         num = a * a * a * e + a * HALF_US * HALF_US * (256 - e);
         mag = (longint'(cfg_yaw_step) * num) / (HALF_US * HALF_US * HALF_US * 256);
         yaw_inc = (c > 0) ? -mag : mag;
      end

      sp.yaw_updated = 1'b0;
      ms_gap = now_ms - last_yaw_ms;
      if (ms_gap > {22'd0, cfg_yaw_int}) begin
         y = yaw_sp_q8 + yaw_inc;
         if (y > YAW_CLAMP) y = YAW_CLAMP;
         if (y < -YAW_CLAMP) y = -YAW_CLAMP;
         yaw_sp_q8 = y;
         last_yaw_ms = now_ms;
         sp.yaw_updated = 1'b1;
      end

      // a zero timestamp still means no frame yet, so elapsed time stays zero
      if (last_slew_us == 32'd0) last_slew_us = now_us;
      dt = now_us - last_slew_us;
      last_slew_us = now_us;
      if (dt > DT_CAP_US) dt = DT_CAP_US;
      step = (longint'(cfg_max_rate) * 256 * longint'(dt)) / US_PER_S;
      pitch_sp_q8 = move_toward(pitch_sp_q8, tilt_of(pp), step);
      roll_sp_q8  = move_toward(roll_sp_q8, tilt_of(rp), step);

      sp.throttle = thr[15:0];
      sp.yaw      = yaw_sp_q8[16:0];
      sp.pitch    = pitch_sp_q8[14:0];
      sp.roll     = roll_sp_q8[14:0];
      return sp;
   endfunction

   function automatic logic [rcss_pkg::REQ_W-1:0] frame_word(logic [11:0] thr,
         logic [11:0] yaw, logic [11:0] pitch, logic [11:0] roll,
         logic [31:0] ms, logic [31:0] us);
      return {us, ms, roll, pitch, yaw, thr};
   endfunction

   // mostly steady timestamps with plausible sticks, now and then a jump or junk pulse
   function automatic logic [rcss_pkg::REQ_W-1:0] random_frame();
      logic [11:0] pw [4];
      int          gap;
      for (int k = 0; k < 4; k++) begin
         case ($urandom_range(9))
            0: pw[k] = 12'($urandom_range(4095));
            1: pw[k] = 12'd1000 + 12'd500 * 12'($urandom_range(2));
            default: pw[k] = 12'($urandom_range(950, 2050));
         endcase
      end
      case ($urandom_range(19))
         0: begin
            run_ms = $urandom;
            run_us = $urandom;
         end
         1: run_us = 32'd0;
         default: begin
            gap = $urandom_range(1, 120);
            run_ms = run_ms + gap;
            run_us = run_us + gap * 1000 + $urandom_range(999);
         end
      endcase
      return frame_word(pw[0], pw[1], pw[2], pw[3], run_ms, run_us);
   endfunction

   function automatic logic [rcss_pkg::CSR_DAT_W-1:0] pick_value(int hi);
      case ($urandom_range(5))
         0: return '0;
         1: return rcss_pkg::CSR_DAT_W'(hi);
         2: return rcss_pkg::CSR_DAT_W'($urandom);
         default: return rcss_pkg::CSR_DAT_W'($urandom_range(hi));
      endcase
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic write_reg(logic [rcss_pkg::CSR_IDX_W-1:0] index,
                            logic [rcss_pkg::CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_reg(index, value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic randomize_registers();
      write_reg(rcss_pkg::REG_THR_LOW,  pick_value(65535));
      write_reg(rcss_pkg::REG_THR_HIGH, pick_value(65535));
      write_reg(rcss_pkg::REG_DEADZONE, pick_value(500));
      write_reg(rcss_pkg::REG_EXPO,     pick_value(256));
      write_reg(rcss_pkg::REG_YAW_STEP, pick_value(4095));
      write_reg(rcss_pkg::REG_YAW_INT,  pick_value(1000));
      write_reg(rcss_pkg::REG_MAX_RATE, pick_value(1023));
      if ($urandom_range(1) == 0)
         write_reg(REG_UNUSED, rcss_pkg::CSR_DAT_W'($urandom));
   endtask

   task automatic set_idle(idle_mode_type mode);
      case (mode)
         IDLE_SENDER:   begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
         IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
         IDLE_BOTH:     begin sender_idle_pct = 10; receiver_stall_pct = 10; end
         default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      endcase
   endtask

   task automatic wait_drained();
      while (frames_pending.size() != 0 || setpoints_due.size() != 0) @(posedge clock);
   endtask

   // frame driver: holds a word until taken, otherwise offers the next one or idles
   always @(negedge clock) begin
      if (!req_tvalid || frame_taken) begin
         frame_taken = 1'b0;
         if (!reset && frames_pending.size() != 0 &&
             $urandom_range(99) >= sender_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= frames_pending[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure, with a long hold-off when one is requested
   always @(negedge clock) begin
      if (holdoff_request) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_request = 1'b0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      setpoint_type               want;
      logic [rcss_pkg::RSP_W-1:0] got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (setpoints_due.size() == 0) begin
               $display("%0t: setpoint word %h with nothing expected", $time, got);
               errors++;
            end else begin
               want = setpoints_due.pop_front();
               check_field("throttle_out",   want.throttle,    got[15:0]);
               check_field("yaw_setpoint",   want.yaw,         got[32:16]);
               check_field("pitch_setpoint", want.pitch,       got[47:33]);
               check_field("roll_setpoint",  want.roll,        got[62:48]);
               check_field("pad bit",        0,                got[63]);
               check_field("yaw_updated",    want.yaw_updated, rsp_tuser);
               words_checked++;
               if (want.yaw_updated) yaw_updates++;
            end
         end
         if (req_tvalid && req_tready) begin
            setpoints_due.push_back(shape_frame(req_tdata));
            void'(frames_pending.pop_front());
            frame_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      idle_mode_type modes [6];
      modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                IDLE_NONE, IDLE_RECEIVER};
      cfg_thr_low  = rcss_pkg::RST_THR_LOW;
      cfg_thr_high = rcss_pkg::RST_THR_HIGH;
      cfg_deadzone = rcss_pkg::RST_DEADZONE;
      cfg_expo     = rcss_pkg::RST_EXPO;
      cfg_yaw_step = rcss_pkg::RST_YAW_STEP;
      cfg_yaw_int  = rcss_pkg::RST_YAW_INT;
      cfg_max_rate = rcss_pkg::RST_MAX_RATE;
      yaw_sp_q8 = 0;
      pitch_sp_q8 = 0;
      roll_sp_q8 = 0;
      last_yaw_ms = '0;
      last_slew_us = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: zero timestamps, saturation, deadzone edge, wraps
      set_idle(IDLE_NONE);
      @(posedge clock);
      frames_pending.push_back(frame_word(0, 0, 0, 0, 0, 0));
      frames_pending.push_back(frame_word(4095, 4095, 4095, 4095, 51, 0));
      frames_pending.push_back(frame_word(1000, 1000, 1000, 1000, 100, 5000));
      frames_pending.push_back(frame_word(2000, 2000, 2000, 2000, 200, 255000));
      frames_pending.push_back(frame_word(1500, 1519, 1500, 1500, 300, 275000));
      frames_pending.push_back(frame_word(1500, 1520, 1500, 1500, 400, 295000));
      frames_pending.push_back(frame_word(999, 2001, 1001, 1999, 500, 315000));
      frames_pending.push_back(frame_word(1234, 1700, 1300, 1700,
                                          32'hFFFF_FFF0, 32'hFFFF_FF00));
      frames_pending.push_back(frame_word(1766, 1300, 1700, 1300,
                                          32'h0000_0030, 32'h0000_2000));
      frames_pending.push_back(frame_word(2500, 1481, 3000, 500,
                                          32'h0000_0060, 32'h0001_0000));
      frames_pending.push_back(frame_word(4095, 4095, 4095, 4095,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
      wait_drained();

      // falling throttle, no deadzone, expo past one, largest yaw steps until clamped
      write_reg(rcss_pkg::REG_THR_LOW,  16'hFFFF);
      write_reg(rcss_pkg::REG_THR_HIGH, 16'h0000);
      write_reg(rcss_pkg::REG_DEADZONE, 16'd0);
      write_reg(rcss_pkg::REG_EXPO,     16'd511);
      write_reg(rcss_pkg::REG_YAW_STEP, 16'd4095);
      write_reg(rcss_pkg::REG_YAW_INT,  16'd0);
      write_reg(rcss_pkg::REG_MAX_RATE, 16'd1023);
      write_reg(REG_UNUSED,             16'hFFFF);
      @(posedge clock);
      frames_pending.push_back(frame_word(1500, 1500, 1000, 2000, 1000, 1000000));
      for (int i = 0; i < 12; i++)
         frames_pending.push_back(frame_word(12'(1000 + i * 90), 1000,
                                             (i % 2) ? 12'd1000 : 12'd2000,
                                             (i % 2) ? 12'd2000 : 12'd1000,
                                             32'(1001 + i), 32'(1010000 + i * 10000)));
      frames_pending.push_back(frame_word(1600, 1600, 1500, 1500, 1012, 1200000));
      frames_pending.push_back(frame_word(2000, 2000, 1500, 1500, 1013, 1210000));
      wait_drained();

      // widest deadzone, linear curve, longest interval, frozen tilt
      write_reg(rcss_pkg::REG_THR_LOW,  16'd0);
      write_reg(rcss_pkg::REG_THR_HIGH, 16'hFFFF);
      write_reg(rcss_pkg::REG_DEADZONE, 16'd500);
      write_reg(rcss_pkg::REG_EXPO,     16'd0);
      write_reg(rcss_pkg::REG_YAW_INT,  16'd1000);
      write_reg(rcss_pkg::REG_MAX_RATE, 16'd0);
      set_idle(IDLE_SENDER);
      @(posedge clock);
      repeat (80) frames_pending.push_back(random_frame());
      wait_drained();

      for (int k = 0; k < 6; k++) begin
         randomize_registers();
         set_idle(modes[k]);
         @(posedge clock);
         repeat (90) frames_pending.push_back(random_frame());
         // result side blocked long enough for the input to back up
         if (k == 0) holdoff_request = 1'b1;
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d setpoint words, %0d with a yaw update, across %0d register writes",
               words_checked, yaw_updates, csr_writes);
      $display("covered saturation, deadzone, expo, yaw clamp, slew caps and timestamp wraps");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/rcss_pkg.sv
rtl/rcss_mul.sv
rtl/rcss_seq.sv
rtl/rc_stick_setpoint_shaper.sv
rtl/rcss_chk.sv
tb/sv/tb.sv
